@@ rtl/core/sstf_disk_scheduler_core_macros.svh @@
// Assertion macros shared by the scheduler RTL.
`ifndef SSTF_DISK_SCHEDULER_CORE_MACROS_SVH
`define SSTF_DISK_SCHEDULER_CORE_MACROS_SVH

`ifndef ASSERT_OFF
// Checked outside reset only.
`define SSTF_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("sstf assertion failed");
// Checked at every edge, reset included.
`define SSTF_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("sstf assertion failed");
`else
`define SSTF_ASSERT(lbl, prop)
`define SSTF_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

@@ rtl/core/sstf_pkg.sv @@
package sstf_pkg;

  localparam int MaxRequests = 64;
  localparam int TrackBits   = 12;
  localparam int IdxBits     = $clog2(MaxRequests);
  localparam int CntBits     = $clog2(MaxRequests + 1);

endpackage

@@ rtl/core/sstf_disk_scheduler_core.sv @@
// Shortest-seek-first scheduler. Requests are loaded one item per cycle into a
// single-port track memory (up to MaxRequests; extras are dropped and flagged on
// every result of that list). The item with last_request starts scheduling: the
// first stored request is emitted first, then each further result comes from a
// full scan of the n stored requests through the one memory read port and one
// shared distance compare. Ties go to the lowest index, so a duplicate track
// follows its twin at distance zero. The block takes no input while a list is
// being scheduled; a waiting final result does not hold off loading of the next
// list.
`include "sstf_disk_scheduler_core_macros.svh"

module sstf_disk_scheduler_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [sstf_pkg::TrackBits-1:0] request_track_i,
  input  logic                          last_request_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [sstf_pkg::TrackBits-1:0] serviced_track_o,
  output logic                          final_in_run_o,
  output logic                          overflow_seen_o
);
  import sstf_pkg::*;

  typedef enum logic [5:0] {
    ST_LOAD    = 6'b000001,
    ST_FETCH   = 6'b000010,
    ST_CAPTURE = 6'b000100,
    ST_PRESENT = 6'b001000,
    ST_SCAN    = 6'b010000,
    ST_TAIL    = 6'b100000
  } state_e;

  state_e state_q, state_d;

  logic [TrackBits-1:0]   mem_q [MaxRequests];
  logic [TrackBits-1:0]   rd_data_q;
  logic [IdxBits-1:0]     rd_addr;

  logic [MaxRequests-1:0] svc_q;
  logic [CntBits-1:0]     count_q;
  logic [CntBits-1:0]     emit_cnt_q;
  logic                   ovf_q;

  logic [IdxBits-1:0]     scan_idx_q;
  logic [IdxBits-1:0]     cmp_idx_q;
  logic                   cmp_valid_q;
  logic                   found_q;
  logic [IdxBits-1:0]     best_idx_q;
  logic [TrackBits-1:0]   best_track_q;
  logic [TrackBits-1:0]   best_dist_q;
  logic [TrackBits-1:0]   head_track_q;

  logic                   out_valid_q;
  logic [TrackBits-1:0]   out_track_q;
  logic                   out_final_q;
  logic                   out_ovf_q;

  logic                   in_fire;
  logic                   store_ok;
  logic                   out_free;
  logic                   present_fire;
  logic                   final_now;
  logic [IdxBits-1:0]     last_idx;
  logic [TrackBits-1:0]   seek_dist;
  logic                   upd;

  assign in_ready_o   = (state_q == ST_LOAD);
  assign in_fire      = in_valid_i && in_ready_o;
  assign store_ok     = (count_q < CntBits'(MaxRequests));
  assign out_free     = !out_valid_q || out_ready_i;
  assign present_fire = (state_q == ST_PRESENT) && out_free;
  assign final_now    = ((emit_cnt_q + CntBits'(1)) == count_q);
  assign last_idx     = IdxBits'(count_q - CntBits'(1));

  assign rd_addr = (state_q == ST_SCAN) ? scan_idx_q : '0;

  // Track memory: one write port for loading, one registered read port.
  always_ff @(posedge clk_i) begin
    if (in_fire && store_ok) begin
      mem_q[count_q[IdxBits-1:0]] <= request_track_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_data_q <= mem_q[rd_addr];
  end

  // Shared distance compare, one stored request per cycle.
  assign seek_dist = (rd_data_q >= head_track_q) ? (rd_data_q - head_track_q)
                                                 : (head_track_q - rd_data_q);
  assign upd  = cmp_valid_q && !svc_q[cmp_idx_q] && (!found_q || (seek_dist < best_dist_q));

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_LOAD: begin
        if (in_fire && last_request_i) state_d = ST_FETCH;
      end
      ST_FETCH:   state_d = ST_CAPTURE;
      ST_CAPTURE: state_d = ST_PRESENT;
      ST_PRESENT: begin
        if (out_free) state_d = final_now ? ST_LOAD : ST_SCAN;
      end
      ST_SCAN: begin
        if (scan_idx_q == last_idx) state_d = ST_TAIL;
      end
      ST_TAIL:    state_d = ST_PRESENT;
      default:    state_d = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      svc_q       <= '0;
      count_q     <= '0;
      emit_cnt_q  <= '0;
      ovf_q       <= 1'b0;
      scan_idx_q  <= '0;
      cmp_valid_q <= 1'b0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cmp_valid_q <= (state_q == ST_SCAN);

      if (out_valid_q && out_ready_i && !present_fire) out_valid_q <= 1'b0;

      if (in_fire) begin
        if (store_ok) begin
          count_q <= count_q + CntBits'(1);
        end else begin
          ovf_q <= 1'b1;
        end
      end

      if (state_q == ST_SCAN) begin
        scan_idx_q <= scan_idx_q + IdxBits'(1);
      end
      if (upd) found_q <= 1'b1;

      if (present_fire) begin
        out_valid_q <= 1'b1;
        scan_idx_q  <= '0;
        found_q     <= 1'b0;
        if (final_now) begin
          // Drop the whole list, ready for the next one.
          svc_q      <= '0;
          count_q    <= '0;
          emit_cnt_q <= '0;
          ovf_q      <= 1'b0;
        end else begin
          svc_q[best_idx_q] <= 1'b1;
          emit_cnt_q        <= emit_cnt_q + CntBits'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_CAPTURE) begin
      best_idx_q   <= '0;
      best_track_q <= rd_data_q;
    end
    if (state_q == ST_SCAN) begin
      cmp_idx_q <= scan_idx_q;
    end
    if (upd) begin
      best_idx_q   <= cmp_idx_q;
      best_track_q <= rd_data_q;
      best_dist_q  <= seek_dist;
    end
    if (present_fire) begin
      head_track_q <= best_track_q;
      out_track_q  <= best_track_q;
      out_final_q  <= final_now;
      out_ovf_q    <= ovf_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign serviced_track_o = out_track_q;
  assign final_in_run_o   = out_final_q;
  assign overflow_seen_o  = out_ovf_q;

  `SSTF_ASSERT(a_count_bound, count_q <= CntBits'(MaxRequests))
  `SSTF_ASSERT(a_emit_below_count, (state_q != ST_LOAD) |-> (emit_cnt_q < count_q))
  `SSTF_ASSERT(a_scan_needs_two, (state_q == ST_SCAN) |-> (count_q >= CntBits'(2)))
  `SSTF_ASSERT(a_scan_finds, (state_q == ST_PRESENT && $past(state_q == ST_TAIL)) |-> found_q)
  `SSTF_ASSERT(a_final_clears, (present_fire && final_now) |=>
    (state_q == ST_LOAD && count_q == '0 && svc_q == '0))

endmodule
